// ----- hw/rtl/cbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbsm_pkg
// Shared types, codes and reset values of the circuit breaker core.
// ----------------------------------------------------------------------------
package cbsm_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int TIME_W         = 64;
  localparam int SPAN_W         = 48;
  localparam int THR_W          = 16;
  localparam int LIMIT_W        = 7;
  localparam int CFG_DATA_W     = 48;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPEN   = 2'd1,
    ST_HALF   = 2'd2
  } brk_state_t;

  // event kinds carried on s_axis_tuser; the fourth code is ignored
  localparam logic [1:0] EV_REQUEST = 2'd0;
  localparam logic [1:0] EV_SUCCESS = 2'd1;
  localparam logic [1:0] EV_FAILURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQ     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_RUN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_RUN = 3'd5;

  localparam logic [LIMIT_W-1:0] PCT_FULL          = 7'd100;
  localparam logic [LIMIT_W-1:0] RST_ERR_LIMIT     = 7'd50;
  localparam logic [SPAN_W-1:0]  RST_SLEEP         = 48'd5000000000;
  localparam logic [SPAN_W-1:0]  RST_INTERVAL      = 48'd1000000000;
  localparam logic [THR_W-1:0]   RST_MIN_REQ       = 16'd10;
  localparam logic [THR_W-1:0]   RST_SUCCESS_RUN   = 16'd3;
  localparam logic [THR_W-1:0]   RST_FAILURE_RUN   = 16'd5;

  typedef struct packed {
    logic       evaluate;     // window is evaluated and cleared
    logic       state_change; // evaluation moved the state
    brk_state_t eval_state;   // state after evaluation
    logic       go_half;      // sleep window passed, trial request
    logic       allow;
    brk_state_t final_state;
  } decide_t;

  // now strictly past base + span; an overflowing sum never passes
  function automatic logic past_deadline(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] base,
                                         input logic [SPAN_W-1:0] span);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W-SPAN_W+1){1'b0}}, span};
    return !sum[TIME_W] && (now > sum[TIME_W-1:0]);
  endfunction

endpackage

// ----- hw/rtl/cbsm_decide.sv -----
// ----------------------------------------------------------------------------
// cbsm_decide
// Next-state decision for one request beat: window evaluation and sleep test.
// ----------------------------------------------------------------------------
module cbsm_decide #(
  parameter int COUNT_BITS = cbsm_pkg::COUNT_BITS_DEF
) (
  input  cbsm_pkg::brk_state_t              state,
  input  logic [cbsm_pkg::TIME_W-1:0]       now,
  input  logic [cbsm_pkg::TIME_W-1:0]       opened_time,
  input  logic [cbsm_pkg::TIME_W-1:0]       evaluated_time,
  input  logic [COUNT_BITS-1:0]             window_successes,
  input  logic [COUNT_BITS-1:0]             window_failures,
  input  logic [COUNT_BITS-1:0]             success_run,
  input  logic [COUNT_BITS-1:0]             failure_run,
  input  logic [cbsm_pkg::LIMIT_W-1:0]      error_percent_limit,
  input  logic [cbsm_pkg::SPAN_W-1:0]       sleep_window_ticks,
  input  logic [cbsm_pkg::SPAN_W-1:0]       eval_interval_ticks,
  input  logic [cbsm_pkg::THR_W-1:0]        min_requests_to_open,
  input  logic [cbsm_pkg::THR_W-1:0]        success_run_to_close,
  input  logic [cbsm_pkg::THR_W-1:0]        failure_run_to_open,
  output cbsm_pkg::decide_t                 decide
);

  localparam int PROD_W = COUNT_BITS + cbsm_pkg::LIMIT_W;
  localparam int CMP_W  = COUNT_BITS + cbsm_pkg::THR_W + 1;

  logic [COUNT_BITS:0]              total;
  logic [cbsm_pkg::LIMIT_W-1:0]     coef;
  logic [PROD_W-1:0]                fail_prod;
  logic [PROD_W-1:0]                succ_prod;
  logic                             rate_hit;
  logic                             enough;
  logic                             fail_run_over;
  logic                             succ_run_met;
  logic                             open_cond;
  logic                             close_cond;
  logic                             eval_due;
  logic                             sleep_past;

  assign total = {1'b0, window_successes} + {1'b0, window_failures};

  // failures*100 >= limit*total  <=>  failures*(100-limit) >= limit*successes
  assign coef      = cbsm_pkg::PCT_FULL - error_percent_limit;
  assign fail_prod = PROD_W'(window_failures) * PROD_W'(coef);
  assign succ_prod = PROD_W'(window_successes) * PROD_W'(error_percent_limit);
  assign rate_hit  = (error_percent_limit <= cbsm_pkg::PCT_FULL) &&
                     (fail_prod >= succ_prod);

  assign enough        = CMP_W'(total) >= CMP_W'(min_requests_to_open);
  assign fail_run_over = CMP_W'(failure_run) > CMP_W'(failure_run_to_open);
  assign succ_run_met  = CMP_W'(success_run) >= CMP_W'(success_run_to_close);

  assign open_cond  = (state == cbsm_pkg::ST_CLOSED) && (window_failures != '0) &&
                      enough && (rate_hit || fail_run_over);
  assign close_cond = (state == cbsm_pkg::ST_HALF) && (window_successes != '0) &&
                      succ_run_met;

  assign eval_due   = cbsm_pkg::past_deadline(now, evaluated_time, eval_interval_ticks);
  assign sleep_past = cbsm_pkg::past_deadline(now, opened_time, sleep_window_ticks);

  always_comb begin
    decide.evaluate     = eval_due && (total != '0);
    decide.state_change = decide.evaluate && (open_cond || close_cond);
    decide.eval_state   = state;
    if (decide.evaluate && open_cond) begin
      decide.eval_state = cbsm_pkg::ST_OPEN;
    end else if (decide.evaluate && close_cond) begin
      decide.eval_state = cbsm_pkg::ST_CLOSED;
    end
    // a fresh open restarts the sleep window at now, so it cannot pass yet
    decide.go_half     = (decide.eval_state != cbsm_pkg::ST_CLOSED) &&
                         !decide.state_change && sleep_past;
    decide.allow       = (decide.eval_state == cbsm_pkg::ST_CLOSED) || decide.go_half;
    decide.final_state = decide.go_half ? cbsm_pkg::ST_HALF : decide.eval_state;
  end

endmodule

// ----- hw/rtl/circuit_breaker_state_machine_core.sv -----
// ----------------------------------------------------------------------------
// circuit_breaker_state_machine_core
// Three-state circuit breaker fed by request and outcome event beats.
// ----------------------------------------------------------------------------
// Path: a request beat goes through the input register, then the decision into the
//   result register; outcome beats give no result beat.
// Throughput: one event beat per cycle; a request beat stalls while the result slot is full.
// Reset (rst, synchronous): breaker closed, times and counters zero,
//   registers at their defaults, both stages empty.
module circuit_breaker_state_machine_core #(
  parameter int COUNT_BITS = cbsm_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // [63:0] now
  input  logic [1:0]                         s_axis_tuser,  // [1:0] mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [0] allowed, [2:1] breaker_state
  input  logic                               cfg_we,
  input  logic [cbsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [cbsm_pkg::LIMIT_W-1:0]  error_percent_limit;
  logic [cbsm_pkg::SPAN_W-1:0]   sleep_window_ticks;
  logic [cbsm_pkg::SPAN_W-1:0]   eval_interval_ticks;
  logic [cbsm_pkg::THR_W-1:0]    min_requests_to_open;
  logic [cbsm_pkg::THR_W-1:0]    success_run_to_close;
  logic [cbsm_pkg::THR_W-1:0]    failure_run_to_open;

  logic                          in_valid;
  logic [1:0]                    in_mode;
  logic [cbsm_pkg::TIME_W-1:0]   in_now;

  cbsm_pkg::brk_state_t          state;
  logic [cbsm_pkg::TIME_W-1:0]   opened_time;
  logic [cbsm_pkg::TIME_W-1:0]   evaluated_time;
  logic [COUNT_BITS-1:0]         window_successes;
  logic [COUNT_BITS-1:0]         window_failures;
  logic [COUNT_BITS-1:0]         success_run;
  logic [COUNT_BITS-1:0]         failure_run;

  logic                          out_valid;
  logic                          out_allowed;
  cbsm_pkg::brk_state_t          out_state;

  logic                          out_free;
  logic                          is_request;
  logic                          proc;
  cbsm_pkg::decide_t             decide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      error_percent_limit  <= cbsm_pkg::RST_ERR_LIMIT;
      sleep_window_ticks   <= cbsm_pkg::RST_SLEEP;
      eval_interval_ticks  <= cbsm_pkg::RST_INTERVAL;
      min_requests_to_open <= cbsm_pkg::RST_MIN_REQ;
      success_run_to_close <= cbsm_pkg::RST_SUCCESS_RUN;
      failure_run_to_open  <= cbsm_pkg::RST_FAILURE_RUN;
    end else if (cfg_we) begin
      case (cfg_index)
        cbsm_pkg::CFG_ERR_LIMIT:   error_percent_limit  <= cfg_data[cbsm_pkg::LIMIT_W-1:0];
        cbsm_pkg::CFG_SLEEP:       sleep_window_ticks   <= cfg_data;
        cbsm_pkg::CFG_INTERVAL:    eval_interval_ticks  <= cfg_data;
        cbsm_pkg::CFG_MIN_REQ:     min_requests_to_open <= cfg_data[cbsm_pkg::THR_W-1:0];
        cbsm_pkg::CFG_SUCCESS_RUN: success_run_to_close <= cfg_data[cbsm_pkg::THR_W-1:0];
        cbsm_pkg::CFG_FAILURE_RUN: failure_run_to_open  <= cfg_data[cbsm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: only request beats need a free result slot
  assign out_free      = !out_valid || m_axis_tready;
  assign is_request    = (in_mode == cbsm_pkg::EV_REQUEST);
  assign proc          = in_valid && (!is_request || out_free);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode <= s_axis_tuser;
      in_now  <= s_axis_tdata;
    end
  end

  cbsm_decide #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decide (
    .state               (state),
    .now                 (in_now),
    .opened_time         (opened_time),
    .evaluated_time      (evaluated_time),
    .window_successes    (window_successes),
    .window_failures     (window_failures),
    .success_run         (success_run),
    .failure_run         (failure_run),
    .error_percent_limit (error_percent_limit),
    .sleep_window_ticks  (sleep_window_ticks),
    .eval_interval_ticks (eval_interval_ticks),
    .min_requests_to_open(min_requests_to_open),
    .success_run_to_close(success_run_to_close),
    .failure_run_to_open (failure_run_to_open),
    .decide              (decide)
  );

  // breaker state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= cbsm_pkg::ST_CLOSED;
      opened_time      <= '0;
      evaluated_time   <= '0;
      window_successes <= '0;
      window_failures  <= '0;
      success_run      <= '0;
      failure_run      <= '0;
    end else if (proc) begin
      case (in_mode)
        cbsm_pkg::EV_SUCCESS: begin
          window_successes <= (window_successes == CNT_MAX) ? CNT_MAX
                                                            : window_successes + 1'b1;
          success_run      <= (success_run == CNT_MAX) ? CNT_MAX : success_run + 1'b1;
          failure_run      <= '0;
        end
        cbsm_pkg::EV_FAILURE: begin
          window_failures <= (window_failures == CNT_MAX) ? CNT_MAX
                                                          : window_failures + 1'b1;
          failure_run     <= (failure_run == CNT_MAX) ? CNT_MAX : failure_run + 1'b1;
          success_run     <= '0;
        end
        cbsm_pkg::EV_REQUEST: begin
          if (decide.evaluate) begin
            window_successes <= '0;
            window_failures  <= '0;
            evaluated_time   <= in_now;
          end
          if (decide.go_half) begin
            opened_time <= in_now;
          end else if (decide.state_change) begin
            opened_time <= (decide.eval_state == cbsm_pkg::ST_OPEN) ? in_now : '0;
          end
          state <= decide.final_state;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && is_request) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_request) begin
      out_allowed <= decide.allow;
      out_state   <= decide.final_state;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_state, out_allowed};

  // a denied request never reports a closed breaker
  a_deny_not_closed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_allowed || out_state != cbsm_pkg::ST_CLOSED))
    else $error("denied beat with closed state");

  // a closed breaker always holds a cleared open time
  a_closed_time_zero: assert property (@(posedge clk) disable iff (rst)
    (state == cbsm_pkg::ST_CLOSED) |-> (opened_time == '0))
    else $error("closed breaker with nonzero open time");

  // closed never goes straight to half-open
  a_no_closed_to_half: assert property (@(posedge clk) disable iff (rst)
    (state == cbsm_pkg::ST_CLOSED) |=> (state != cbsm_pkg::ST_HALF))
    else $error("closed to half-open in one step");

  // an outcome beat leaves its own window count nonzero and clears the other run
  a_success_update: assert property (@(posedge clk) disable iff (rst)
    (proc && in_mode == cbsm_pkg::EV_SUCCESS) |=>
      (window_successes != '0 && failure_run == '0))
    else $error("success beat not counted");

  a_failure_update: assert property (@(posedge clk) disable iff (rst)
    (proc && in_mode == cbsm_pkg::EV_FAILURE) |=>
      (window_failures != '0 && success_run == '0))
    else $error("failure beat not counted");

endmodule
